// ----- rtl/lwig_pkg.sv -----
// Package for the Lyndon word index generator.
// Holds the fixed field widths and register index codes; no dependencies.
package lwig_pkg;

  localparam int unsigned LEN_W = 4;   // word and prefix length fields
  localparam int unsigned IDX_W = 64;  // bijective word index
  localparam int unsigned CFG_W = 5;   // widest configuration register

  typedef logic [LEN_W-1:0] len_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CFG_W-1:0] cfg_data_t;

  typedef enum logic [0:0] {
    CFG_ALPHABET_SIZE = 1'b0,
    CFG_MAX_LENGTH    = 1'b1
  } cfg_index_e;

endpackage

// ----- rtl/lwig_if.sv -----
// Valid/ready channel interfaces for the request and result transactions.
// Depends on lwig_pkg for the payload types.
interface lwig_req_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface lwig_res_if;
  logic            valid;
  logic            ready;
  lwig_pkg::idx_t  word_index;
  lwig_pkg::len_t  word_length;
  logic            done_res;

  modport source (output valid, output word_index, output word_length, output done_res,
                  input ready);
  modport sink   (input valid, input word_index, input word_length, input done_res,
                  output ready);
endinterface

// ----- rtl/lwig_letters.sv -----
// Letter store of the current word: one write and one registered read port.
// Entry zero reads as zero after reset or a clear until it is written.
module lwig_letters #(
  parameter int unsigned DEPTH = 15,
  parameter int unsigned WIDTH = 4,
  parameter int unsigned AW    = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             clr0_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;
  logic             zero0_q;
  logic             rzero_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero0_q <= 1'b1;
      rzero_q <= 1'b0;
    end else begin
      rzero_q <= zero0_q && (raddr_i == '0);
      if (clr0_i) begin
        zero0_q <= 1'b1;
      end else if (we_i && (waddr_i == '0)) begin
        zero0_q <= 1'b0;
      end
    end
  end

  assign rdata_o = rzero_q ? '0 : rdata_q;

endmodule

// ----- rtl/lwig_mac.sv -----
// Index accumulator: acc <= acc * radix + digit + 1, one digit a cycle while en_i is set.
// Depends on lwig_pkg for the index width.
module lwig_mac #(
  parameter int unsigned RADIX_W = 5,
  parameter int unsigned DIGIT_W = 4
) (
  input  logic                clk_i,
  input  logic                clear_i,
  input  logic                en_i,
  input  logic [RADIX_W-1:0]  radix_i,
  input  logic [DIGIT_W-1:0]  digit_i,
  output lwig_pkg::idx_t      acc_o
);

  lwig_pkg::idx_t acc_q;
  lwig_pkg::idx_t acc_d;

  always_comb begin
    acc_d = acc_q * lwig_pkg::IDX_W'(radix_i) + lwig_pkg::IDX_W'(digit_i)
            + lwig_pkg::IDX_W'(1);
  end

  always_ff @(posedge clk_i) begin
    if (clear_i) begin
      acc_q <= '0;
    end else if (en_i) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

// ----- rtl/lyndon_word_index_generator.sv -----
// Lyndon word index generator, top level.
// Depends on lwig_pkg, lwig_if, lwig_letters and lwig_mac.
//
// Every request transaction on req_i returns exactly one result transaction
// on res_o: the next Lyndon word over the configured alphabet, shortest
// words first and lexicographic within a length (Duval's walk). The result
// carries the word length and its bijective index (digit = letter + 1, first
// letter most significant). A request with restart set begins again at the
// first word. After the last word every result has done_res set and zero
// length and index.
// The block works on one request at a time and is not ready meanwhile. The
// letters live in a small memory with one registered read port, and all
// steps of the walk go through that port: extending the prefix reads and
// then writes each letter, stripping a top letter is a single check step,
// and building the index takes one letter per step through the single
// multiply-accumulate unit. A one-letter alphabet crosses every length in
// one request. A stalled receiver holds only the output register; the
// next request is still accepted and its result waits until the register
// is free. Reset (asynchronous, active low) loads alphabet_size 2,
// max_length 4 and restarts the walk with no clearing pass. Configuration
// writes belong between requests and are used from the next request on.
module lyndon_word_index_generator #(
  parameter int unsigned MAX_LEN     = 15,
  parameter int unsigned LETTER_BITS = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [0:0]            cfg_index_i,
  input  lwig_pkg::cfg_data_t   cfg_data_i,
  lwig_req_if.sink              req_i,
  lwig_res_if.source            res_o
);

  localparam int unsigned AW       = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned RADIX_W  = LETTER_BITS + 1;
  localparam int unsigned ALPH_MAX = 2 ** LETTER_BITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_EXT_RD,
    S_EXT_WR,
    S_STRIP_CHK,
    S_ZERO,
    S_IDX_ACC,
    S_EMIT
  } state_e;

  state_e state_q;

  // Configuration registers.
  lwig_pkg::cfg_data_t alph_cfg_q;
  lwig_pkg::len_t      maxl_cfg_q;

  // Walk state.
  lwig_pkg::len_t prefix_q;
  lwig_pkg::len_t target_q;
  lwig_pkg::len_t m_q;
  lwig_pkg::len_t cnt_q;
  logic           resume_q;
  logic           finished_q;
  logic           done_pend_q;

  // Output register.
  logic           out_valid_q;
  lwig_pkg::idx_t out_index_q;
  lwig_pkg::len_t out_length_q;
  logic           out_done_q;

  // Effective configuration: alphabet clamped to 1..2^LETTER_BITS, length
  // clamped to MAX_LEN.
  logic [RADIX_W-1:0]     alph;
  logic [LETTER_BITS-1:0] top;
  lwig_pkg::len_t         maxl;

  always_comb begin
    if (alph_cfg_q == '0) begin
      alph = RADIX_W'(1);
    end else if (alph_cfg_q > lwig_pkg::CFG_W'(ALPH_MAX)) begin
      alph = RADIX_W'(ALPH_MAX);
    end else begin
      alph = alph_cfg_q[RADIX_W-1:0];
    end
    top = LETTER_BITS'(alph - RADIX_W'(1));
    maxl = (maxl_cfg_q > lwig_pkg::LEN_W'(MAX_LEN)) ? lwig_pkg::LEN_W'(MAX_LEN)
                                                   : maxl_cfg_q;
  end

  // Letter memory and accumulator controls.
  logic                   mem_clr0;
  logic                   mem_we;
  lwig_pkg::len_t         mem_waddr;
  logic [LETTER_BITS-1:0] mem_wdata;
  lwig_pkg::len_t         mem_raddr;
  logic [LETTER_BITS-1:0] mem_rdata;
  logic                   mac_clear;
  logic                   mac_en;
  lwig_pkg::idx_t         mac_acc;
  logic                   req_fire;

  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;

  always_comb begin
    mem_clr0  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = prefix_q;
    mem_wdata = mem_rdata;
    mem_raddr = '0;
    mac_clear = 1'b0;
    mac_en    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        mem_clr0 = req_fire && req_i.restart;
      end
      S_CHECK: begin
        // Start of index building: clear the accumulator, fetch letter zero.
        mac_clear = 1'b1;
        mem_raddr = '0;
      end
      S_EXT_RD: begin
        mem_raddr = (prefix_q < target_q) ? (prefix_q - m_q)
                                          : (prefix_q - lwig_pkg::LEN_W'(1));
      end
      S_EXT_WR: begin
        mem_we    = 1'b1;
        mem_waddr = prefix_q;
        mem_wdata = mem_rdata;
      end
      S_STRIP_CHK: begin
        mem_raddr = prefix_q - lwig_pkg::LEN_W'(2);
        if (mem_rdata < top) begin
          mem_we    = 1'b1;
          mem_waddr = prefix_q - lwig_pkg::LEN_W'(1);
          mem_wdata = mem_rdata + LETTER_BITS'(1);
        end
      end
      S_ZERO: begin
        mem_clr0 = (lwig_pkg::LEN_W + 1)'(target_q) + 5'd1 <= (lwig_pkg::LEN_W + 1)'(maxl);
      end
      S_IDX_ACC: begin
        mac_en    = 1'b1;
        mem_raddr = cnt_q + lwig_pkg::LEN_W'(1);
      end
      S_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  lwig_letters #(
    .DEPTH (MAX_LEN),
    .WIDTH (LETTER_BITS),
    .AW    (AW)
  ) u_letters (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clr0_i  (mem_clr0),
    .we_i    (mem_we),
    .waddr_i (mem_waddr[AW-1:0]),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr[AW-1:0]),
    .rdata_o (mem_rdata)
  );

  lwig_mac #(
    .RADIX_W (RADIX_W),
    .DIGIT_W (LETTER_BITS)
  ) u_mac (
    .clk_i   (clk_i),
    .clear_i (mac_clear),
    .en_i    (mac_en),
    .radix_i (alph),
    .digit_i (mem_rdata),
    .acc_o   (mac_acc)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      alph_cfg_q  <= lwig_pkg::CFG_W'(2);
      maxl_cfg_q  <= lwig_pkg::LEN_W'(4);
      prefix_q    <= lwig_pkg::LEN_W'(1);
      target_q    <= lwig_pkg::LEN_W'(1);
      m_q         <= '0;
      cnt_q       <= '0;
      resume_q    <= 1'b0;
      finished_q  <= 1'b0;
      done_pend_q <= 1'b0;
      out_valid_q <= 1'b0;
      out_done_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (lwig_pkg::cfg_index_e'(cfg_index_i))
          lwig_pkg::CFG_ALPHABET_SIZE: alph_cfg_q <= cfg_data_i;
          lwig_pkg::CFG_MAX_LENGTH:    maxl_cfg_q <= cfg_data_i[lwig_pkg::LEN_W-1:0];
          default: begin
          end
        endcase
      end

      // In S_EMIT the output register is reloaded below whenever it drains.
      if (out_valid_q && res_o.ready && state_q != S_EMIT) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (req_fire) begin
            if (req_i.restart) begin
              prefix_q   <= lwig_pkg::LEN_W'(1);
              target_q   <= lwig_pkg::LEN_W'(1);
              resume_q   <= 1'b0;
              finished_q <= 1'b0;
            end
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (finished_q) begin
            done_pend_q <= 1'b1;
            state_q     <= S_EMIT;
          end else if (target_q > maxl || target_q == '0 || prefix_q == '0 ||
                       prefix_q > lwig_pkg::LEN_W'(MAX_LEN)) begin
            finished_q  <= 1'b1;
            done_pend_q <= 1'b1;
            state_q     <= S_EMIT;
          end else begin
            m_q <= prefix_q;
            if (!resume_q && prefix_q == target_q) begin
              cnt_q       <= '0;
              resume_q    <= 1'b1;
              done_pend_q <= 1'b0;
              state_q     <= S_IDX_ACC;
            end else begin
              resume_q <= 1'b0;
              state_q  <= S_EXT_RD;
            end
          end
        end
        S_EXT_RD: begin
          // Either fetch the letter one period back, or the last letter for
          // the top-letter strip once the prefix has reached the target.
          state_q <= (prefix_q < target_q) ? S_EXT_WR : S_STRIP_CHK;
        end
        S_EXT_WR: begin
          prefix_q <= prefix_q + lwig_pkg::LEN_W'(1);
          state_q  <= S_EXT_RD;
        end
        S_STRIP_CHK: begin
          if (mem_rdata < top) begin
            // Increment of the last letter happens on the memory port.
            state_q <= S_CHECK;
          end else begin
            prefix_q <= prefix_q - lwig_pkg::LEN_W'(1);
            if (prefix_q == lwig_pkg::LEN_W'(1)) begin
              state_q <= S_ZERO;
            end
          end
        end
        S_ZERO: begin
          // All letters were top letters: move to the next length.
          target_q <= target_q + lwig_pkg::LEN_W'(1);
          if (mem_clr0) begin
            prefix_q <= lwig_pkg::LEN_W'(1);
          end else begin
            finished_q <= 1'b1;
          end
          state_q <= S_CHECK;
        end
        S_IDX_ACC: begin
          cnt_q <= cnt_q + lwig_pkg::LEN_W'(1);
          if (cnt_q + lwig_pkg::LEN_W'(1) == m_q) begin
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid_q || res_o.ready) begin
            out_valid_q  <= 1'b1;
            out_done_q   <= done_pend_q;
            out_index_q  <= done_pend_q ? '0 : mac_acc;
            out_length_q <= done_pend_q ? '0 : m_q;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.word_index  = out_index_q;
  assign res_o.word_length = out_length_q;
  assign res_o.done_res    = out_done_q;

endmodule

// ----- dv/tb_lyndon_word_index_generator.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for lyndon_word_index_generator: a queue-fed driver
// and a monitor check every result against a built-in Lyndon word walk.
// Depends on lwig_pkg, the lwig_req_if / lwig_res_if interfaces and the RTL top.
module tb_lyndon_word_index_generator;

  // Alphabet is capped at 2^4 letters and words at 15 letters, as in the block.
  localparam int unsigned WORD_MAX   = 15;
  localparam int unsigned LETTER_W   = 4;
  localparam int unsigned ALPHA_CAP  = 1 << LETTER_W;
  localparam int unsigned ITEMS      = 1850;
  // The longest request is a one-letter alphabet that runs through every
  // length, and each side may add its drawn idle gap on top.
  // Nothing else holds the channels quiet for long, so this is ample.
  localparam int unsigned QUIET_LIMIT  = 4000;
  localparam int unsigned DRAIN_CYCLES = 64;

  // One result transaction: the emitted word, or the done marker.
  typedef struct packed {
    lwig_pkg::idx_t word_index;
    lwig_pkg::len_t word_len;
    logic           done;
  } lyndon_word_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b1;
  logic                 cfg_we = 1'b0;
  lwig_pkg::cfg_index_e cfg_index = lwig_pkg::CFG_ALPHABET_SIZE;
  lwig_pkg::cfg_data_t  cfg_data = '0;

  lwig_req_if req_if ();
  lwig_res_if res_if ();

  lyndon_word_index_generator DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .req_i       (req_if),
    .res_o       (res_if)
  );

  always #5 clk_i = ~clk_i;

  // Requests waiting to be driven (the restart bit of each) and the words
  // that the block still owes us, oldest first.
  bit           pending_reqs[$];
  lyndon_word_t owed_words[$];

  // Traffic shaping: a quiet side never idles; otherwise it draws its idle
  // gap afresh from draw_wait for each transaction.
  bit          sender_quiet   = 1'b0;
  bit          receiver_quiet = 1'b0;
  int unsigned send_gap;
  int unsigned recv_stall;

  int unsigned error_count   = 0;
  int unsigned req_count     = 0;
  int unsigned restart_count = 0;
  int unsigned word_count    = 0;
  int unsigned done_count    = 0;
  int unsigned phase_count   = 0;
  int unsigned longest_word  = 0;
  int unsigned quiet_cycles  = 0;

  // Shadow copy of the configuration and of the walk state.
  lwig_pkg::cfg_data_t   cfg_alphabet;
  lwig_pkg::len_t        cfg_max_len;
  logic [LETTER_W-1:0]   cur_word [WORD_MAX];
  int unsigned           built_len;
  int unsigned           goal_len;
  bit                    advance_next;
  bit                    exhausted;

  function automatic int unsigned draw_wait(bit quiet);
    return quiet ? 0 : $urandom_range(11, 0);
  endfunction

  function automatic void start_over();
    for (int unsigned k = 0; k < WORD_MAX; k++) cur_word[k] = '0;
    built_len    = 1;
    goal_len     = 1;
    advance_next = 1'b0;
    exhausted    = 1'b0;
  endfunction

  // Appends one request to the queue of pending requests.
  function automatic void queue_req(bit restart);
    pending_reqs = {pending_reqs, restart};
  endfunction

  // Serves one request with Duval's walk, run separately for each length.
  // The walk stops as soon as the current prefix reaches the goal length for
  // the first time; the following request first moves it on.
  function automatic lyndon_word_t next_lyndon_word(bit restart);
    int unsigned  alph;
    int unsigned  maxl;
    int unsigned  top;
    int unsigned  period;
    int unsigned  k;
    bit           emitted;
    lyndon_word_t res;
    res     = '0;
    emitted = 1'b0;
    if (restart) start_over();
    // Zero letters behave as one, and oversized settings saturate.
    alph = (cfg_alphabet == 0) ? 1 : cfg_alphabet;
    if (alph > ALPHA_CAP) alph = ALPHA_CAP;
    top  = alph - 1;
    maxl = (cfg_max_len > WORD_MAX) ? WORD_MAX : cfg_max_len;
    while (!exhausted && !emitted) begin
      if (goal_len > maxl || goal_len == 0 || built_len == 0 || built_len > WORD_MAX) begin
        // Also covers a maximum length lowered below the current word.
        exhausted = 1'b1;
      end else if (!advance_next && built_len == goal_len) begin
        // Bijective digits: letter plus one, first letter most significant.
        for (k = 0; k < built_len; k++) begin
          res.word_index = res.word_index * lwig_pkg::idx_t'(alph)
                           + lwig_pkg::idx_t'(cur_word[k]) + 1;
        end
        res.word_len = lwig_pkg::len_t'(built_len);
        advance_next = 1'b1;
        emitted      = 1'b1;
      end else begin
        advance_next = 1'b0;
        period       = built_len;
        // Extend periodically up to the goal length.
        while (built_len < goal_len) begin
          cur_word[built_len] = cur_word[built_len - period];
          built_len++;
        end
        // Strip top letters; a letter left over from a larger alphabet counts
        // as a top letter.
        while (built_len > 0 && cur_word[built_len - 1] >= top) built_len--;
        if (built_len == 0) begin
          goal_len++;
          if (goal_len > maxl) begin
            exhausted = 1'b1;
          end else begin
            cur_word[0] = '0;
            built_len   = 1;
          end
        end else begin
          cur_word[built_len - 1] = cur_word[built_len - 1] + 1'b1;
        end
      end
    end
    if (!emitted) res.done = 1'b1;
    return res;
  endfunction

  // The shadow state follows register writes and accepted requests at the
  // same edges as the block does, so every word is predicted on acceptance.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_alphabet = 5'd2;
      cfg_max_len  = 4'd4;
      start_over();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          lwig_pkg::CFG_ALPHABET_SIZE: cfg_alphabet = cfg_data;
          lwig_pkg::CFG_MAX_LENGTH:    cfg_max_len  = lwig_pkg::len_t'(cfg_data);
          default: ;
        endcase
      end
      if (req_if.valid && req_if.ready) begin
        owed_words = {owed_words, next_lyndon_word(req_if.restart)};
        req_count++;
        if (req_if.restart) restart_count++;
      end
    end
  end

  // Request driver. The gap drawn for a transaction starts counting once it
  // has been accepted.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid   <= 1'b0;
      req_if.restart <= 1'b0;
      send_gap       <= 0;
    end else if (!req_if.valid || req_if.ready) begin
      if (send_gap != 0) begin
        req_if.valid <= 1'b0;
        send_gap     <= send_gap - 1;
      end else if (pending_reqs.size() != 0) begin
        req_if.valid   <= 1'b1;
        req_if.restart <= pending_reqs.pop_front();
        send_gap       <= draw_wait(sender_quiet);
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  task automatic check_field(string name, lwig_pkg::idx_t want, lwig_pkg::idx_t got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  // Result monitor. After each accepted result the receiver stalls for a
  // freshly drawn number of cycles.
  always @(posedge clk_i or negedge rst_ni) begin : result_monitor
    int unsigned  stall;
    lyndon_word_t want;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      recv_stall   <= 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (owed_words.size() == 0) begin
          $display("%0t: result with no request outstanding: index %0d, length %0d, done %0d",
                   $time, res_if.word_index, res_if.word_length, res_if.done_res);
          error_count++;
        end else begin
          want = owed_words.pop_front();
          check_field("word_index", want.word_index, res_if.word_index);
          check_field("word_length", lwig_pkg::idx_t'(want.word_len),
                      lwig_pkg::idx_t'(res_if.word_length));
          check_field("done_res", lwig_pkg::idx_t'(want.done),
                      lwig_pkg::idx_t'(res_if.done_res));
          if (want.done) begin
            done_count++;
          end else begin
            word_count++;
            if (want.word_len > longest_word) longest_word = want.word_len;
          end
        end
        stall = draw_wait(receiver_quiet);
        recv_stall   <= stall;
        res_if.ready <= (stall == 0);
      end else if (recv_stall != 0) begin
        recv_stall   <= recv_stall - 1;
        res_if.ready <= (recv_stall == 1);
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run if neither channel moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d results outstanding",
               $time, quiet_cycles, owed_words.size());
      $display("tb_lyndon_word_index_generator: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Writes one register; returns at a falling edge so that later queue
  // appends never race the driver.
  task automatic write_reg(lwig_pkg::cfg_index_e idx, lwig_pkg::cfg_data_t value);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  // Waits until every request has gone out and every owed word has come back.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_reqs.size() != 0 || req_if.valid || owed_words.size() != 0);
  endtask

  function automatic lwig_pkg::cfg_data_t pick_alphabet();
    case ($urandom_range(7, 0))
      0:       return 5'd0;
      1:       return 5'd1;
      2:       return 5'd16;
      3:       return lwig_pkg::cfg_data_t'($urandom_range(31, 17));
      4, 5:    return lwig_pkg::cfg_data_t'($urandom_range(4, 2));
      default: return lwig_pkg::cfg_data_t'($urandom_range(16, 1));
    endcase
  endfunction

  function automatic lwig_pkg::cfg_data_t pick_max_length();
    case ($urandom_range(7, 0))
      0:       return 5'd0;
      1:       return 5'd1;
      2:       return 5'd15;
      3, 4, 5: return lwig_pkg::cfg_data_t'($urandom_range(6, 2));
      default: return lwig_pkg::cfg_data_t'($urandom_range(15, 0));
    endcase
  endfunction

  initial begin : stimulus
    int unsigned n;
    int unsigned queued;
    rst_ni <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset settings (two letters, up to length four): eight words, then the
    // done marker twice, then a restart brings back the first word.
    repeat (10) queue_req(1'b0);
    queue_req(1'b1);
    wait_idle();

    // A zero alphabet acts as a single letter: one word, then done.
    write_reg(lwig_pkg::CFG_ALPHABET_SIZE, 5'd0);
    write_reg(lwig_pkg::CFG_MAX_LENGTH, 5'd3);
    queue_req(1'b1);
    queue_req(1'b0);
    wait_idle();

    // An oversized alphabet saturates at sixteen letters; maximum length 15.
    write_reg(lwig_pkg::CFG_ALPHABET_SIZE, 5'd31);
    write_reg(lwig_pkg::CFG_MAX_LENGTH, 5'd15);
    queue_req(1'b1);
    queue_req(1'b0);
    wait_idle();

    // A zero maximum length is done at once.
    write_reg(lwig_pkg::CFG_MAX_LENGTH, 5'd0);
    queue_req(1'b1);
    wait_idle();

    // Maximum length lowered below the current word mid-run.
    write_reg(lwig_pkg::CFG_ALPHABET_SIZE, 5'd2);
    write_reg(lwig_pkg::CFG_MAX_LENGTH, 5'd5);
    queue_req(1'b1);
    repeat (2) queue_req(1'b0);
    wait_idle();
    write_reg(lwig_pkg::CFG_MAX_LENGTH, 5'd1);
    queue_req(1'b0);
    wait_idle();

    // Alphabet lowered mid-run: letters above the new top get stripped.
    write_reg(lwig_pkg::CFG_ALPHABET_SIZE, 5'd5);
    write_reg(lwig_pkg::CFG_MAX_LENGTH, 5'd3);
    queue_req(1'b1);
    repeat (3) queue_req(1'b0);
    wait_idle();
    write_reg(lwig_pkg::CFG_ALPHABET_SIZE, 5'd2);
    repeat (2) queue_req(1'b0);
    wait_idle();

    // Random phases. Each phase drains completely, so the sender also pauses
    // until nothing is owed before the next settings go in. Most requests
    // just walk on, so long runs reach the end of the word list; some phases
    // keep walking from where the previous settings left the state.
    queued = req_count;
    while (queued < ITEMS) begin
      phase_count++;
      sender_quiet   = ($urandom_range(3, 0) == 0);
      receiver_quiet = ($urandom_range(3, 0) == 0);
      if ($urandom_range(9, 0) < 7) write_reg(lwig_pkg::CFG_ALPHABET_SIZE, pick_alphabet());
      if ($urandom_range(9, 0) < 7) write_reg(lwig_pkg::CFG_MAX_LENGTH, pick_max_length());
      n = $urandom_range(200, 30);
      queue_req(1'($urandom_range(1, 0)));
      for (int unsigned k = 1; k < n; k++) queue_req($urandom_range(99, 0) < 3);
      queued += n;
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Covered %0d requests (%0d restarts) over %0d random settings phases.",
             req_count, restart_count, phase_count);
    $display("Checked %0d words up to %0d letters and %0d end-of-list results.",
             word_count, longest_word, done_count);
    if (error_count == 0) begin
      $display("tb_lyndon_word_index_generator: done, clean");
    end else begin
      $display("tb_lyndon_word_index_generator: done, errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/lwig_pkg.sv
rtl/lwig_if.sv
rtl/lwig_letters.sv
rtl/lwig_mac.sv
rtl/lyndon_word_index_generator.sv
dv/tb_lyndon_word_index_generator.sv
